>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define PMDQ_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define PMDQ_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/core/pmdq_pkg.sv
// Shared types and constants of the pulse metal detect qualifier.
// Depends on nothing; used by all modules of the block.
`default_nettype none

package pmdq_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int WEIGHT_BITS    = 17;
    localparam int WEIGHT_FRAC    = 16;
    localparam int COUNT_BITS     = 16;
    localparam int CALIB_BITS     = 17;
    localparam int LEVEL_BITS     = 20;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'h10000;

    localparam logic [COUNT_BITS-1:0]  DISCARD_RST     = 16'd0;
    localparam logic [COUNT_BITS-1:0]  CALIB_COUNT_RST = 16'd64;
    localparam logic [WEIGHT_BITS-1:0] BASE_WEIGHT_RST = 17'd64;
    localparam logic [WEIGHT_BITS-1:0] OUT_WEIGHT_RST  = 17'd16384;
    localparam logic [LEVEL_BITS-1:0]  DETECT_LVL_RST  = 20'd25600;
    localparam logic [LEVEL_BITS-1:0]  CLEAR_LVL_RST   = 20'd12800;
    localparam logic [COUNT_BITS-1:0]  DETECT_RUN_RST  = 16'd3;
    localparam logic [COUNT_BITS-1:0]  CLEAR_RUN_RST   = 16'd3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DISCARD     = 3'd0,
        CFG_CALIB_COUNT = 3'd1,
        CFG_BASE_WEIGHT = 3'd2,
        CFG_OUT_WEIGHT  = 3'd3,
        CFG_DETECT_LVL  = 3'd4,
        CFG_CLEAR_LVL   = 3'd5,
        CFG_DETECT_RUN  = 3'd6,
        CFG_CLEAR_RUN   = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_METAL = 2'd1,
        MODE_CALIB = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_BASE,
        SEQ_DIV_WAIT,
        SEQ_BASE_EMA_WAIT,
        SEQ_FILT,
        SEQ_FILT_EMA_WAIT,
        SEQ_DECIDE,
        SEQ_WRITE
    } seq_state_t;

    // Handshake of a serial arithmetic unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

`default_nettype wire

>>> rtl/core/pmdq_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pmdq_pkg for the unit status type.
`default_nettype none

module pmdq_divider #(
    parameter int DIVIDEND_BITS = 37,
    parameter int DIVISOR_BITS  = 17,
    parameter int QUOTIENT_BITS = 20
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [DIVIDEND_BITS-1:0]   dividend,
    input  wire logic [DIVISOR_BITS-1:0]    divisor,
    output pmdq_pkg::unit_status_t          status,
    output logic      [QUOTIENT_BITS-1:0]   quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] dvd_reg;
    logic [DIVISOR_BITS-1:0]  dsr_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [QUOTIENT_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, dvd_reg[DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = !diff[DIVISOR_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIVIDEND_BITS-2:0], 1'b0};
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            quo_reg <= {quo_reg[QUOTIENT_BITS-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/pmdq_ema.sv
// Bit-serial exponential average unit: y + round(w * (x - y) / 2^16).
// Depends on pmdq_pkg for weight widths and the unit status type.
`default_nettype none

module pmdq_ema #(
    parameter int VALUE_BITS = 21
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic        [pmdq_pkg::WEIGHT_BITS-1:0] weight,
    input  wire logic signed [VALUE_BITS-1:0]          x,
    input  wire logic signed [VALUE_BITS-1:0]          y,
    output pmdq_pkg::unit_status_t                     status,
    output logic signed      [VALUE_BITS-1:0]          result
);

    localparam int WB       = pmdq_pkg::WEIGHT_BITS;
    localparam int WF       = pmdq_pkg::WEIGHT_FRAC;
    localparam int ACC_BITS = VALUE_BITS + 1 + WB;
    localparam int CNT_BITS = $clog2(WB + 1);
    localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (WF - 1);

    logic [ACC_BITS-1:0]          addend_reg;
    logic [ACC_BITS-1:0]          acc_reg;
    logic [WB-1:0]                wt_reg;
    logic signed [VALUE_BITS-1:0] y_reg;
    logic [CNT_BITS-1:0]          cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [VALUE_BITS:0]          diff;
    logic [ACC_BITS-1:0]          rounded;

    assign diff    = {x[VALUE_BITS-1], x} - {y[VALUE_BITS-1], y};
    assign rounded = acc_reg + ROUND_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One weight bit per cycle: add the shifted difference where the bit is set.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addend_reg <= {{WB{diff[VALUE_BITS]}}, diff};
            acc_reg    <= '0;
            wt_reg     <= weight;
            y_reg      <= y;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + (wt_reg[0] ? addend_reg : '0);
            addend_reg <= {addend_reg[ACC_BITS-2:0], 1'b0};
            wt_reg     <= {1'b0, wt_reg[WB-1:1]};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = y_reg + $signed(rounded[WF +: VALUE_BITS]);

endmodule

`default_nettype wire

>>> rtl/core/pulse_metal_detect_qualifier.sv
// Pulse metal detect qualifier: takes one converter sample per excitation
// pulse and returns one result transaction per sample. While calibrating, the
// first discard_count samples are skipped and the baseline is the rounded mean
// of the samples after them, found by a bit-serial divider. Once
// calibrated, the baseline tracks the input by an exponential average. The
// sample minus the baseline then runs through a second exponential average
// whose first output copies its input. Both averages share one bit-serial
// multiply unit. A sample that enters the calibration mean starts the divider,
// waits on it, starts the filter average, waits on it, is decided, loads the
// result and returns to idle to take the next sample. A calibrated sample runs
// the baseline average in place of the divider, a discarded sample skips the
// baseline step, and the very first sample, whose filter copies through,
// skips the filter average. One sample is worked on at a time, and the input
// stalls for that span. A finished result waits in the output register, so the
// next sample is taken while the last result is still stalled; a result that
// is still waiting there when the next one is ready holds the sequencer in its
// final step for as long as the output stalls. The magnitude of the filter
// output drives a calibrating / no metal / metal state machine that needs a
// run of samples strictly above detect_level to enter the metal state and a
// run strictly below clear_level to leave it; a run length of zero acts as one.
// Configuration registers are written through the cfg_wr_en port; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Depends on pmdq_pkg, pmdq_divider and pmdq_ema.
`default_nettype none

module pulse_metal_detect_qualifier #(
    parameter int SAMPLE_BITS   = pmdq_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = pmdq_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // configuration write port
    input  wire logic                                     cfg_wr_en,
    input  wire logic [pmdq_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire logic [pmdq_pkg::CFG_DATA_BITS-1:0]       cfg_wr_data,
    // sample channel
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic [SAMPLE_BITS-1:0]                   adc_sample,
    // result channel
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic [SAMPLE_BITS-1:0]                        sample_echo,
    output logic signed [SAMPLE_BITS+FRACTION_BITS:0]     filtered_signal,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0]          baseline_level,
    output logic                                          calibrated,
    output logic [1:0]                                    detector_state
);

    localparam int SIG_BITS   = SAMPLE_BITS + FRACTION_BITS;
    localparam int FILT_BITS  = SIG_BITS + 1;
    localparam int CB         = pmdq_pkg::CALIB_BITS;
    localparam int NB         = pmdq_pkg::COUNT_BITS;
    localparam int WB         = pmdq_pkg::WEIGHT_BITS;
    localparam int LB         = pmdq_pkg::LEVEL_BITS;
    // At most 2^16 samples enter the sum before calibration completes.
    localparam int SUM_BITS   = NB + SAMPLE_BITS;
    localparam int DVD_BITS   = SUM_BITS + FRACTION_BITS + 1;
    localparam int CMP_BITS   = (FILT_BITS > LB) ? FILT_BITS : LB;
    localparam logic [CB-1:0] CALIB_MAX = '1;
    localparam logic [NB-1:0] RUN_MAX   = '1;

    // Configuration registers.
    logic [NB-1:0] discard_reg;
    logic [NB-1:0] calib_count_reg;
    logic [WB-1:0] base_weight_reg;
    logic [WB-1:0] out_weight_reg;
    logic [LB-1:0] detect_lvl_reg;
    logic [LB-1:0] clear_lvl_reg;
    logic [NB-1:0] detect_run_reg;
    logic [NB-1:0] clear_run_reg;

    // Sequencer and detector state.
    pmdq_pkg::seq_state_t state_reg, state_next;
    logic [SAMPLE_BITS-1:0]      sample_reg, sample_next;
    logic [SIG_BITS-1:0]         baseline_reg, baseline_next;
    logic signed [FILT_BITS-1:0] filter_reg, filter_next;
    logic                        primed_reg, primed_next;
    logic                        calib_done_reg, calib_done_next;
    logic [CB-1:0]               calib_cnt_reg, calib_cnt_next;
    logic [SUM_BITS-1:0]         calib_sum_reg, calib_sum_next;
    logic [NB-1:0]               enter_cnt_reg, enter_cnt_next;
    logic [NB-1:0]               leave_cnt_reg, leave_cnt_next;
    pmdq_pkg::mode_t             mode_reg, mode_next;

    // Result register.
    logic                        out_valid_reg, out_valid_next;
    logic                        out_load;
    logic [SAMPLE_BITS-1:0]      out_sample_reg;
    logic signed [FILT_BITS-1:0] out_filter_reg;
    logic [SIG_BITS-1:0]         out_baseline_reg;
    logic                        out_calib_reg;
    pmdq_pkg::mode_t             out_mode_reg;

    // Datapath helpers.
    logic [SIG_BITS-1:0]         xq;
    logic [CB-1:0]               cnt_inc;
    logic                        keep_sample;
    logic [CB-1:0]               mean_n;
    logic [SUM_BITS-1:0]         sum_add;
    logic [DVD_BITS-1:0]         dividend;
    logic signed [FILT_BITS-1:0] shifted;
    logic [FILT_BITS-1:0]        mag;
    logic                        div_start;
    logic                        ema_start;
    logic [WB-1:0]               ema_weight;
    logic signed [FILT_BITS-1:0] ema_x;
    logic signed [FILT_BITS-1:0] ema_y;
    logic signed [FILT_BITS-1:0] ema_result;
    logic [SIG_BITS-1:0]         quotient;
    pmdq_pkg::unit_status_t      div_status;
    pmdq_pkg::unit_status_t      ema_status;
    pmdq_pkg::mode_t             dec_mode;
    logic [NB-1:0]               dec_enter;
    logic [NB-1:0]               dec_leave;

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_reg     <= pmdq_pkg::DISCARD_RST;
            calib_count_reg <= pmdq_pkg::CALIB_COUNT_RST;
            base_weight_reg <= pmdq_pkg::BASE_WEIGHT_RST;
            out_weight_reg  <= pmdq_pkg::OUT_WEIGHT_RST;
            detect_lvl_reg  <= pmdq_pkg::DETECT_LVL_RST;
            clear_lvl_reg   <= pmdq_pkg::CLEAR_LVL_RST;
            detect_run_reg  <= pmdq_pkg::DETECT_RUN_RST;
            clear_run_reg   <= pmdq_pkg::CLEAR_RUN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (pmdq_pkg::cfg_index_t'(cfg_index))
                pmdq_pkg::CFG_DISCARD:     discard_reg     <= cfg_wr_data[NB-1:0];
                pmdq_pkg::CFG_CALIB_COUNT: calib_count_reg <= cfg_wr_data[NB-1:0];
                pmdq_pkg::CFG_BASE_WEIGHT: base_weight_reg <= cfg_wr_data[WB-1:0];
                pmdq_pkg::CFG_OUT_WEIGHT:  out_weight_reg  <= cfg_wr_data[WB-1:0];
                pmdq_pkg::CFG_DETECT_LVL:  detect_lvl_reg  <= cfg_wr_data[LB-1:0];
                pmdq_pkg::CFG_CLEAR_LVL:   clear_lvl_reg   <= cfg_wr_data[LB-1:0];
                pmdq_pkg::CFG_DETECT_RUN:  detect_run_reg  <= cfg_wr_data[NB-1:0];
                pmdq_pkg::CFG_CLEAR_RUN:   clear_run_reg   <= cfg_wr_data[NB-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Calibration arithmetic.
    // ------------------------------------------------------------------
    assign xq          = {sample_reg, {FRACTION_BITS{1'b0}}};
    assign cnt_inc     = (calib_cnt_reg == CALIB_MAX) ? calib_cnt_reg : calib_cnt_reg + 1'b1;
    assign keep_sample = cnt_inc > {1'b0, discard_reg};
    assign mean_n      = cnt_inc - {1'b0, discard_reg};
    assign sum_add     = calib_sum_reg + SUM_BITS'(sample_reg);
    // Mean with round half up: (sum * 2^F + n/2) / n.
    assign dividend    = {1'b0, sum_add, {FRACTION_BITS{1'b0}}}
                       + DVD_BITS'(mean_n[CB-1:1]);

    assign shifted = $signed({1'b0, xq}) - $signed({1'b0, baseline_reg});

    // The shared average unit works on the baseline or on the output filter.
    always_comb
    begin
        if (state_reg == pmdq_pkg::SEQ_BASE)
        begin
            ema_weight = (base_weight_reg > pmdq_pkg::WEIGHT_ONE) ?
                         pmdq_pkg::WEIGHT_ONE : base_weight_reg;
            ema_x      = $signed({1'b0, xq});
            ema_y      = $signed({1'b0, baseline_reg});
        end
        else
        begin
            ema_weight = (out_weight_reg > pmdq_pkg::WEIGHT_ONE) ?
                         pmdq_pkg::WEIGHT_ONE : out_weight_reg;
            ema_x      = shifted;
            ema_y      = filter_reg;
        end
    end

    pmdq_divider #(
        .DIVIDEND_BITS (DVD_BITS),
        .DIVISOR_BITS  (CB),
        .QUOTIENT_BITS (SIG_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (mean_n),
        .status   (div_status),
        .quotient (quotient)
    );

    pmdq_ema #(
        .VALUE_BITS (FILT_BITS)
    ) u_ema (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ema_start),
        .weight (ema_weight),
        .x      (ema_x),
        .y      (ema_y),
        .status (ema_status),
        .result (ema_result)
    );

    // ------------------------------------------------------------------
    // Detector decision on the new filter value. The sample that completes
    // calibration is judged in the no metal mode with cleared run counters.
    // ------------------------------------------------------------------
    assign mag = filter_reg[FILT_BITS-1] ? FILT_BITS'(-filter_reg) : filter_reg;

    always_comb
    begin
        dec_mode  = mode_reg;
        dec_enter = enter_cnt_reg;
        dec_leave = leave_cnt_reg;
        if (!calib_done_reg)
        begin
            dec_mode  = pmdq_pkg::MODE_CALIB;
            dec_enter = '0;
            dec_leave = '0;
        end
        else
        begin
            if (mode_reg == pmdq_pkg::MODE_CALIB)
            begin
                dec_mode  = pmdq_pkg::MODE_NONE;
                dec_enter = '0;
                dec_leave = '0;
            end
            unique case (dec_mode)
                pmdq_pkg::MODE_METAL:
                begin
                    if (CMP_BITS'(mag) < CMP_BITS'(clear_lvl_reg))
                    begin
                        dec_leave = (dec_leave == RUN_MAX) ? dec_leave : dec_leave + 1'b1;
                        if (dec_leave >= clear_run_reg)
                        begin
                            dec_mode  = pmdq_pkg::MODE_NONE;
                            dec_enter = '0;
                            dec_leave = '0;
                        end
                    end
                    else
                    begin
                        dec_leave = '0;
                    end
                end
                pmdq_pkg::MODE_NONE:
                begin
                    if (CMP_BITS'(mag) > CMP_BITS'(detect_lvl_reg))
                    begin
                        dec_enter = (dec_enter == RUN_MAX) ? dec_enter : dec_enter + 1'b1;
                        if (dec_enter >= detect_run_reg)
                        begin
                            dec_mode  = pmdq_pkg::MODE_METAL;
                            dec_enter = '0;
                            dec_leave = '0;
                        end
                    end
                    else
                    begin
                        dec_enter = '0;
                    end
                end
                default:
                begin
                    dec_mode = mode_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: baseline, then output filter, then decision, then result.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        baseline_next   = baseline_reg;
        filter_next     = filter_reg;
        primed_next     = primed_reg;
        calib_done_next = calib_done_reg;
        calib_cnt_next  = calib_cnt_reg;
        calib_sum_next  = calib_sum_reg;
        enter_cnt_next  = enter_cnt_reg;
        leave_cnt_next  = leave_cnt_reg;
        mode_next       = mode_reg;
        div_start       = 1'b0;
        ema_start       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            pmdq_pkg::SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = adc_sample;
                    state_next  = pmdq_pkg::SEQ_BASE;
                end
            end
            pmdq_pkg::SEQ_BASE:
            begin
                if (!calib_done_reg)
                begin
                    calib_cnt_next = cnt_inc;
                    if (keep_sample)
                    begin
                        calib_sum_next = sum_add;
                        div_start      = 1'b1;
                        if (cnt_inc >= {1'b0, calib_count_reg})
                        begin
                            calib_done_next = 1'b1;
                        end
                        state_next = pmdq_pkg::SEQ_DIV_WAIT;
                    end
                    else
                    begin
                        // Discarded sample: baseline keeps its old value.
                        state_next = pmdq_pkg::SEQ_FILT;
                    end
                end
                else
                begin
                    ema_start  = 1'b1;
                    state_next = pmdq_pkg::SEQ_BASE_EMA_WAIT;
                end
            end
            pmdq_pkg::SEQ_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    baseline_next = quotient;
                    state_next    = pmdq_pkg::SEQ_FILT;
                end
            end
            pmdq_pkg::SEQ_BASE_EMA_WAIT:
            begin
                if (ema_status.done)
                begin
                    baseline_next = ema_result[SIG_BITS-1:0];
                    state_next    = pmdq_pkg::SEQ_FILT;
                end
            end
            pmdq_pkg::SEQ_FILT:
            begin
                if (!primed_reg)
                begin
                    filter_next = shifted;
                    primed_next = 1'b1;
                    state_next  = pmdq_pkg::SEQ_DECIDE;
                end
                else
                begin
                    ema_start  = 1'b1;
                    state_next = pmdq_pkg::SEQ_FILT_EMA_WAIT;
                end
            end
            pmdq_pkg::SEQ_FILT_EMA_WAIT:
            begin
                if (ema_status.done)
                begin
                    filter_next = ema_result;
                    state_next  = pmdq_pkg::SEQ_DECIDE;
                end
            end
            pmdq_pkg::SEQ_DECIDE:
            begin
                mode_next      = dec_mode;
                enter_cnt_next = dec_enter;
                leave_cnt_next = dec_leave;
                state_next     = pmdq_pkg::SEQ_WRITE;
            end
            pmdq_pkg::SEQ_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = pmdq_pkg::SEQ_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmdq_pkg::SEQ_IDLE;
            baseline_reg   <= '0;
            filter_reg     <= '0;
            primed_reg     <= 1'b0;
            calib_done_reg <= 1'b0;
            calib_cnt_reg  <= '0;
            calib_sum_reg  <= '0;
            enter_cnt_reg  <= '0;
            leave_cnt_reg  <= '0;
            mode_reg       <= pmdq_pkg::MODE_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            baseline_reg   <= baseline_next;
            filter_reg     <= filter_next;
            primed_reg     <= primed_next;
            calib_done_reg <= calib_done_next;
            calib_cnt_reg  <= calib_cnt_next;
            calib_sum_reg  <= calib_sum_next;
            enter_cnt_reg  <= enter_cnt_next;
            leave_cnt_reg  <= leave_cnt_next;
            mode_reg       <= mode_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        if (out_load)
        begin
            out_sample_reg   <= sample_reg;
            out_filter_reg   <= filter_reg;
            out_baseline_reg <= baseline_reg;
            out_calib_reg    <= calib_done_reg;
            out_mode_reg     <= mode_reg;
        end
    end

    assign in_stall        = (state_reg != pmdq_pkg::SEQ_IDLE);
    assign out_valid       = out_valid_reg;
    assign sample_echo     = out_sample_reg;
    assign filtered_signal = out_filter_reg;
    assign baseline_level  = out_baseline_reg;
    assign calibrated      = out_calib_reg;
    assign detector_state  = out_mode_reg;

endmodule

`default_nettype wire

>>> rtl/core/pmdq_checker.sv
// Port-level checker of the pulse metal detect qualifier, bound to the top level.
// Depends on pmdq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pmdq_checker #(
    parameter int SAMPLE_BITS = pmdq_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [SAMPLE_BITS-1:0] sample_echo,
    input wire logic                   calibrated,
    input wire logic [1:0]             detector_state
);

    // A stalled result transaction stays offered with the same sample.
    `PMDQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_echo), "stalled result changed")

    // One sample at a time: the input stalls right after a transaction.
    `PMDQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled while busy")

    // The calibrating state is shown exactly while calibration is open.
    `PMDQ_ASSERT_SAME(a_calib_state, out_valid, calibrated == (detector_state != pmdq_pkg::MODE_CALIB), "calibrated flag and state disagree")

    // Calibration never reopens once a calibrated result has gone out.
    `PMDQ_ASSERT_NEXT(a_calib_sticky, out_valid && !out_stall && calibrated, !out_valid || calibrated, "calibration reopened")

endmodule

bind pulse_metal_detect_qualifier pmdq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_pmdq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_echo    (sample_echo),
    .calibrated     (calibrated),
    .detector_state (detector_state)
);

`default_nettype wire

>>> sim/pmdq_result_checker.sv
// Checker for the pulse metal detect qualifier: watches the configuration
// port and both channels, predicts each result and compares it field by field.
// Depends on pmdq_pkg for the register index and detector mode codes.
`timescale 1ns / 1ps

module pmdq_result_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pmdq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pmdq_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [11:0]                         adc_sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [11:0]                         sample_echo,
    input  logic signed [20:0]                  filtered_signal,
    input  logic [19:0]                         baseline_level,
    input  logic                                calibrated,
    input  logic [1:0]                          detector_state,
    output int                                  errors,
    output int                                  pending
);

    typedef struct packed {
        logic [11:0]        echo;
        logic signed [20:0] filt;
        logic [19:0]        base;
        logic               cal;
        pmdq_pkg::mode_t    mode;
    } detect_result_t;

    localparam longint FILT_BIAS = 64'sd1 << 20;

    detect_result_t expected_results[$];

    // Configuration copy.
    longint unsigned discard_q, calib_q, base_w, out_w, det_lvl, clr_lvl, det_run, clr_run;
    // Detector state copy.
    longint unsigned base_q, cal_cnt, cal_sum, enter_cnt, leave_cnt;
    longint          filt_q;
    bit              primed, cal_done;
    pmdq_pkg::mode_t mode_q;

    function automatic longint unsigned blend(longint unsigned w, longint unsigned x,
                                              longint unsigned y);
        longint unsigned a;
        a = (w > 65536) ? 65536 : w;
        return (a * x + (65536 - a) * y + 32768) >> 16;
    endfunction

    task automatic advance_detector(input logic [11:0] raw);
        longint unsigned xq, n, mag;
        longint          shifted;
        detect_result_t  r;
        xq = longint'(raw) << 8;
        if (!cal_done)
        begin
            if (cal_cnt < 131071) cal_cnt++;
            if (cal_cnt > discard_q)
            begin
                n = cal_cnt - discard_q;
                cal_sum += raw;
                base_q = (((cal_sum << 8) + n / 2) / n) & 20'hFFFFF;
                if (cal_cnt >= calib_q) cal_done = 1;
            end
        end
        else
        begin
            base_q = blend(base_w, xq, base_q) & 20'hFFFFF;
        end

        shifted = longint'(xq) - longint'(base_q);
        if (!primed)
        begin
            filt_q = shifted;
            primed = 1;
        end
        else
        begin
            filt_q = longint'(blend(out_w, shifted + FILT_BIAS, filt_q + FILT_BIAS)) - FILT_BIAS;
        end

        if (!cal_done)
        begin
            mode_q = pmdq_pkg::MODE_CALIB;
            enter_cnt = 0;
            leave_cnt = 0;
        end
        else
        begin
            // The sample that ends calibration is judged as in the no metal mode.
            if (mode_q == pmdq_pkg::MODE_CALIB)
            begin
                mode_q = pmdq_pkg::MODE_NONE;
                enter_cnt = 0;
                leave_cnt = 0;
            end
            mag = (filt_q < 0) ? -filt_q : filt_q;
            if (mode_q == pmdq_pkg::MODE_METAL)
            begin
                if (mag < clr_lvl)
                begin
                    if (leave_cnt < 65535) leave_cnt++;
                    if (leave_cnt >= clr_run)
                    begin
                        mode_q = pmdq_pkg::MODE_NONE;
                        enter_cnt = 0;
                        leave_cnt = 0;
                    end
                end
                else
                begin
                    leave_cnt = 0;
                end
            end
            else if (mode_q == pmdq_pkg::MODE_NONE)
            begin
                if (mag > det_lvl)
                begin
                    if (enter_cnt < 65535) enter_cnt++;
                    if (enter_cnt >= det_run)
                    begin
                        mode_q = pmdq_pkg::MODE_METAL;
                        enter_cnt = 0;
                        leave_cnt = 0;
                    end
                end
                else
                begin
                    enter_cnt = 0;
                end
            end
        end

        r.echo = raw;
        r.filt = filt_q[20:0];
        r.base = base_q[19:0];
        r.cal  = cal_done;
        r.mode = mode_q;
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        detect_result_t e;
        if (!rst_n)
        begin
            discard_q = pmdq_pkg::DISCARD_RST;     calib_q = pmdq_pkg::CALIB_COUNT_RST;
            base_w    = pmdq_pkg::BASE_WEIGHT_RST; out_w   = pmdq_pkg::OUT_WEIGHT_RST;
            det_lvl   = pmdq_pkg::DETECT_LVL_RST;  clr_lvl = pmdq_pkg::CLEAR_LVL_RST;
            det_run   = pmdq_pkg::DETECT_RUN_RST;  clr_run = pmdq_pkg::CLEAR_RUN_RST;
            base_q = 0; filt_q = 0; primed = 0; cal_done = 0; cal_cnt = 0;
            cal_sum = 0; enter_cnt = 0; leave_cnt = 0; mode_q = pmdq_pkg::MODE_NONE;
            expected_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (pmdq_pkg::cfg_index_t'(cfg_index))
                    pmdq_pkg::CFG_DISCARD:     discard_q = cfg_wr_data[15:0];
                    pmdq_pkg::CFG_CALIB_COUNT: calib_q   = cfg_wr_data[15:0];
                    pmdq_pkg::CFG_BASE_WEIGHT: base_w    = cfg_wr_data[16:0];
                    pmdq_pkg::CFG_OUT_WEIGHT:  out_w     = cfg_wr_data[16:0];
                    pmdq_pkg::CFG_DETECT_LVL:  det_lvl   = cfg_wr_data[19:0];
                    pmdq_pkg::CFG_CLEAR_LVL:   clr_lvl   = cfg_wr_data[19:0];
                    pmdq_pkg::CFG_DETECT_RUN:  det_run   = cfg_wr_data[15:0];
                    pmdq_pkg::CFG_CLEAR_RUN:   clr_run   = cfg_wr_data[15:0];
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no sample pending");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (sample_echo !== e.echo)
                    begin
                        $error("sample_echo expected %0d actual %0d", e.echo, sample_echo);
                        errors++;
                    end
                    if (filtered_signal !== e.filt)
                    begin
                        $error("filtered_signal expected %0d actual %0d", e.filt,
                               filtered_signal);
                        errors++;
                    end
                    if (baseline_level !== e.base)
                    begin
                        $error("baseline_level expected %0d actual %0d", e.base,
                               baseline_level);
                        errors++;
                    end
                    if (calibrated !== e.cal)
                    begin
                        $error("calibrated expected %0d actual %0d", e.cal, calibrated);
                        errors++;
                    end
                    if (detector_state !== e.mode)
                    begin
                        $error("detector_state expected %0d actual %0d", e.mode,
                               detector_state);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall) advance_detector(adc_sample);
            pending = expected_results.size();
        end
    end

endmodule

>>> sim/tb_pulse_metal_detect_qualifier.sv
// Testbench top for the pulse metal detect qualifier: clock, reset, sample and
// configuration stimulus, and the verdict. Depends on pmdq_pkg, the block and
// pmdq_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_pulse_metal_detect_qualifier;

    // This settle time covers one sample still in flight after the last result
    // has been seen.
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 235;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] adc_sample = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] sample_echo;
    logic signed [20:0] filtered_signal;
    logic [19:0] baseline_level;
    logic        calibrated;
    logic [1:0]  detector_state;
    int          fail_count;
    int          results_owed;
    int          cycle_count = 0;
    bit          gaps_on = 1'b1;

    always #5 clk = ~clk;

    pulse_metal_detect_qualifier i_dut (
        .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data,
        .in_valid, .in_stall, .adc_sample,
        .out_valid, .out_stall, .sample_echo, .filtered_signal,
        .baseline_level, .calibrated, .detector_state
    );

    pmdq_result_checker i_checker (
        .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data,
        .in_valid, .in_stall, .adc_sample,
        .out_valid, .out_stall, .sample_echo, .filtered_signal,
        .baseline_level, .calibrated, .detector_state,
        .errors(fail_count), .pending(results_owed)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // The receiver cycles through four stall styles in turn: none, coin-flip, long
    // stalls that outlast a whole sample, and rare stalls.
    always @(posedge clk)
    begin
        unique case ((cycle_count >> 8) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(1);
            2: out_stall <= (cycle_count % 64) < 58;
            default: out_stall <= ($urandom_range(7) == 0);
        endcase
    end

    // Only one nonblocking write to cfg_wr_en per step: the caller lowers the
    // enable once the whole batch is written.
    task automatic write_reg(input pmdq_pkg::cfg_index_t idx, input logic [19:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
    endtask

    // Holds the sample until the block takes it, then maybe opens a gap.
    int burst_left = 0;
    task automatic send_sample(input logic [11:0] value);
        int gap;
        in_valid   <= 1'b1;
        adc_sample <= value;
        do @(posedge clk); while (in_stall);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(24);
            gap = gaps_on ? $urandom_range(6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Pressure point: every expected result drains before going on.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly pulse-shaped episodes: a quiet stretch near a resting level, then
    // a run pushed above or below it so the detector must qualify and clear.
    // The rest is raw noise over the full code range.
    task automatic send_episode(ref int sent);
        int rest, swing, quiet, hit, k;
        rest = $urandom_range(1200, 2900);
        if ($urandom_range(9) < 7)
        begin
            quiet = $urandom_range(1, 10);
            hit   = $urandom_range(1, 10);
            swing = $urandom_range(100, 2500);
            if ($urandom_range(1)) swing = -swing;
            for (k = 0; k < quiet; k++)
            begin
                send_sample(12'(rest + $urandom_range(16) - 8));
                sent++;
            end
            for (k = 0; k < hit; k++)
            begin
                if (rest + swing > 4095)   send_sample(12'd4095);
                else if (rest + swing < 0) send_sample(12'd0);
                else send_sample(12'(rest + swing + $urandom_range(40) - 20));
                sent++;
            end
        end
        else
        begin
            for (k = $urandom_range(1, 8); k > 0; k--)
            begin
                send_sample(12'($urandom_range(4095)));
                sent++;
            end
        end
    endtask

    task automatic set_phase(input int p);
        unique case (p)
            0:
            begin
                write_reg(pmdq_pkg::CFG_BASE_WEIGHT, 20'd0);
                write_reg(pmdq_pkg::CFG_OUT_WEIGHT,  20'd65536);
                write_reg(pmdq_pkg::CFG_DETECT_LVL,  20'd0);
                write_reg(pmdq_pkg::CFG_CLEAR_LVL,   20'hFFFFF);
                write_reg(pmdq_pkg::CFG_DETECT_RUN,  20'd0);
                write_reg(pmdq_pkg::CFG_CLEAR_RUN,   20'd0);
            end
            1:
            begin
                // Weights above one must act as exactly one.
                write_reg(pmdq_pkg::CFG_BASE_WEIGHT, 20'h1FFFF);
                write_reg(pmdq_pkg::CFG_OUT_WEIGHT,  20'h1FFFF);
                write_reg(pmdq_pkg::CFG_DETECT_LVL,  20'hFFFFF);
                write_reg(pmdq_pkg::CFG_CLEAR_LVL,   20'd0);
                write_reg(pmdq_pkg::CFG_DETECT_RUN,  20'd65535);
                write_reg(pmdq_pkg::CFG_CLEAR_RUN,   20'd65535);
                // Calibration is long over, so these must change nothing.
                write_reg(pmdq_pkg::CFG_DISCARD,     20'd65535);
                write_reg(pmdq_pkg::CFG_CALIB_COUNT, 20'd65535);
            end
            2:
            begin
                write_reg(pmdq_pkg::CFG_BASE_WEIGHT, 20'd65536);
                write_reg(pmdq_pkg::CFG_OUT_WEIGHT,  20'd1);
                write_reg(pmdq_pkg::CFG_DETECT_LVL,  20'd5000);
                write_reg(pmdq_pkg::CFG_CLEAR_LVL,   20'd4000);
                write_reg(pmdq_pkg::CFG_DETECT_RUN,  20'd1);
                write_reg(pmdq_pkg::CFG_CLEAR_RUN,   20'd2);
                write_reg(pmdq_pkg::CFG_DISCARD,     20'd0);
                write_reg(pmdq_pkg::CFG_CALIB_COUNT, 20'd0);
            end
            default:
            begin
                write_reg(pmdq_pkg::CFG_BASE_WEIGHT, 20'($urandom_range(4096)));
                write_reg(pmdq_pkg::CFG_OUT_WEIGHT,  20'($urandom_range(2000, 65536)));
                write_reg(pmdq_pkg::CFG_DETECT_LVL,  20'($urandom_range(20000, 300000)));
                write_reg(pmdq_pkg::CFG_CLEAR_LVL,   20'($urandom_range(20000)));
                write_reg(pmdq_pkg::CFG_DETECT_RUN,  20'($urandom_range(6)));
                write_reg(pmdq_pkg::CFG_CLEAR_RUN,   20'($urandom_range(6)));
            end
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int sent, p, k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Calibration happens once per reset: skip three samples, then
        // average eleven before the baseline starts tracking.
        write_reg(pmdq_pkg::CFG_DISCARD, 20'd3);
        write_reg(pmdq_pkg::CFG_CALIB_COUNT, 20'd14);
        cfg_wr_en <= 1'b0;
        @(posedge clk);

        // Directed part: code extremes and alternating bit patterns first
        // (the discarded samples still drive the filter against a zero
        // baseline), then the calibration mean, then a hard swing that
        // should qualify and clear under the reset thresholds.
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'hAAA);
        send_sample(12'h555);
        for (k = 0; k < 10; k++) send_sample(12'(2000 + k * 7));
        send_sample(12'd0);
        for (k = 0; k < 4; k++) send_sample(12'd4095);
        for (k = 0; k < 6; k++) send_sample(12'd2003);
        drain_results();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            set_phase(p);
            gaps_on = (p % 3) != 1;
            sent = 0;
            while (sent < PHASE_ITEMS) send_episode(sent);
            drain_results();
        end

        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
